// ===== sv/fcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// fcbf_pkg: shared types and constants for the flow-controlled byte FIFO
// Command classes, the queued command record, field widths and defaults.
// ----------------------------------------------------------------------------
package fcbf_pkg;

  // Field widths fixed by the channel formats
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int COUNT_W = 11;
  localparam int TOTAL_W = 32;

  // Parameter defaults
  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BURST_DEF = 64;

  // Capacity register value after reset
  localparam logic [COUNT_W-1:0] CAP_RESET = 11'd1024;

  // Operation codes on the request channel
  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP   = 3'd3;
  localparam logic [OP_W-1:0] OP_END   = 3'd4;

  // Decoded request class, one-hot
  typedef enum logic [5:0] {
    K_WRITE = 6'b000001,
    K_READ  = 6'b000010,
    K_PEEK  = 6'b000100,
    K_POP   = 6'b001000,
    K_END   = 6'b010000,
    K_NOP   = 6'b100000
  } kind_t;

  // One classified request as it travels to the back end
  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [LEN_W-1:0]   length;
  } cmd_t;

  // Back-end sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EMIT  = 3'b100
  } back_state_t;

endpackage

// ===== sv/fcbf_cmd_if.sv =====
// ----------------------------------------------------------------------------
// fcbf_cmd_if: request channel of the byte FIFO
// Valid/ready handshake carrying op, data_byte and length.
// ----------------------------------------------------------------------------
interface fcbf_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [fcbf_pkg::OP_W-1:0]        op;
  logic [fcbf_pkg::BYTE_W-1:0]      data_byte;
  logic [fcbf_pkg::LEN_W-1:0]       length;

  modport source (output valid, output op, output data_byte, output length, input ready);
  modport sink   (input valid, input op, input data_byte, input length, output ready);
endinterface

// ===== sv/fcbf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fcbf_rsp_if: result channel of the byte FIFO
// Valid/ready handshake carrying one delivered byte and the buffer status.
// ----------------------------------------------------------------------------
interface fcbf_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [fcbf_pkg::BYTE_W-1:0]      out_byte;
  logic                             byte_valid;
  logic                             last;
  logic                             accepted;
  logic [fcbf_pkg::COUNT_W-1:0]     occupancy;
  logic [fcbf_pkg::COUNT_W-1:0]     free_space;
  logic [fcbf_pkg::TOTAL_W-1:0]     total_written;
  logic [fcbf_pkg::TOTAL_W-1:0]     total_read;
  logic                             input_done;
  logic                             end_of_stream;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output accepted, output occupancy, output free_space,
                  output total_written, output total_read, output input_done,
                  output end_of_stream, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input accepted, input occupancy, input free_space,
                  input total_written, input total_read, input input_done,
                  input end_of_stream, output ready);
endinterface

// ===== sv/fcbf_front.sv =====
// ----------------------------------------------------------------------------
// fcbf_front: request intake
// Takes requests from the channel, decodes the op into a request class and
// holds the classified request until the command queue takes it.
// ----------------------------------------------------------------------------
module fcbf_front (
  input  logic               clk,
  input  logic               rst,
  fcbf_cmd_if.sink           cmd,
  output logic               push_valid,
  input  logic               push_ready,
  output fcbf_pkg::cmd_t     push_cmd
);

  logic           hold_valid;
  fcbf_pkg::cmd_t hold_cmd;
  fcbf_pkg::kind_t kind_dec;
  logic           take;

  // Accept whenever the holding register is empty or drains this cycle
  assign cmd.ready = !hold_valid || push_ready;
  assign take      = cmd.valid && cmd.ready;

  // Classify the op; unused codes become a status-only request
  always_comb begin
    case (cmd.op)
      fcbf_pkg::OP_WRITE: kind_dec = fcbf_pkg::K_WRITE;
      fcbf_pkg::OP_READ:  kind_dec = fcbf_pkg::K_READ;
      fcbf_pkg::OP_PEEK:  kind_dec = fcbf_pkg::K_PEEK;
      fcbf_pkg::OP_POP:   kind_dec = fcbf_pkg::K_POP;
      fcbf_pkg::OP_END:   kind_dec = fcbf_pkg::K_END;
      default:            kind_dec = fcbf_pkg::K_NOP;
    endcase
  end

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  // Capture the classified request
  always_ff @(posedge clk) begin
    if (take) begin
      hold_cmd.kind      <= kind_dec;
      hold_cmd.data_byte <= cmd.data_byte;
      hold_cmd.length    <= cmd.length;
    end
  end

  assign push_valid = hold_valid;
  assign push_cmd   = hold_cmd;

endmodule

// ===== sv/fcbf_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// fcbf_cmd_queue: two-entry command queue
// Decouples request intake from execution so either side can stall alone.
// ----------------------------------------------------------------------------
module fcbf_cmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  fcbf_pkg::cmd_t     push_cmd,
  output logic               pop_valid,
  input  logic               pop_ready,
  output fcbf_pkg::cmd_t     pop_cmd
);

  fcbf_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== sv/fcbf_back.sv =====
// ----------------------------------------------------------------------------
// fcbf_back: execution engine of the byte FIFO
// Owns the byte store, pointers, counters and capacity register; carries out
// one queued command at a time and drives the registered result channel.
// ----------------------------------------------------------------------------
module fcbf_back #(
  parameter int DEPTH     = fcbf_pkg::DEPTH_DEF,
  parameter int MAX_BURST = fcbf_pkg::MAX_BURST_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fcbf_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  fcbf_pkg::cmd_t                cmd,
  fcbf_rsp_if.source                    rsp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int SUM_W = PTR_W + 1;
  localparam int CW    = fcbf_pkg::COUNT_W;
  localparam int LW    = fcbf_pkg::LEN_W;
  localparam int TW    = fcbf_pkg::TOTAL_W;
  localparam int BW    = fcbf_pkg::BYTE_W;
  localparam logic [31:0]      DEPTH32 = 32'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CW-1:0]    BURST_C = CW'(MAX_BURST);

  // Byte store
  logic [BW-1:0] mem [DEPTH];
  logic [BW-1:0] rd_data;
  logic          mem_we;

  // Architectural state
  fcbf_pkg::back_state_t state, state_next;
  logic [CW-1:0]    capacity;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CW-1:0]    count, count_next;
  logic [TW-1:0]    wtotal, wtotal_next;
  logic [TW-1:0]    rtotal, rtotal_next;
  logic             ended, ended_next;

  // Burst state
  logic [PTR_W-1:0] ptr, ptr_next;
  logic [LW-1:0]    remain, remain_next;
  logic             is_read, is_read_next;

  // Result staging
  logic             rsp_valid;
  logic             out_free;
  logic             load_out;
  logic [BW-1:0]    o_byte;
  logic             o_bvalid;
  logic             o_last;
  logic             o_acc;
  logic [CW-1:0]    free_next;

  // Derived values
  logic [CW-1:0]    eff_cap;
  logic [CW-1:0]    len_ext;
  logic [CW-1:0]    len_min;
  logic [CW-1:0]    n_full;
  logic [LW-1:0]    n;
  logic [SUM_W-1:0] head_sum;
  logic [PTR_W-1:0] head_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_MAX) ? '0 : p + PTR_W'(1);
  endfunction

  // Clamp capacity to the store size
  assign eff_cap = ({21'b0, capacity} > DEPTH32) ? CW'(DEPTH32) : capacity;

  // Clamp the request length to bytes held and burst limit
  assign len_ext = CW'(cmd.length);
  assign len_min = (len_ext < count) ? len_ext : count;
  assign n_full  = (len_min > BURST_C) ? BURST_C : len_min;
  assign n       = n_full[LW-1:0];

  // Head after dropping n bytes, wrapped once
  assign head_sum = {1'b0, head} + SUM_W'(n);
  assign head_pop = (head_sum >= DEPTH_S) ? PTR_W'(head_sum - DEPTH_S) : head_sum[PTR_W-1:0];

  assign out_free = !rsp_valid || rsp.ready;

  // Sequence commands and compute next state
  always_comb begin
    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    wtotal_next  = wtotal;
    rtotal_next  = rtotal;
    ended_next   = ended;
    ptr_next     = ptr;
    remain_next  = remain;
    is_read_next = is_read;
    cmd_ready    = 1'b0;
    mem_we       = 1'b0;
    load_out     = 1'b0;
    o_byte       = '0;
    o_bvalid     = 1'b0;
    o_last       = 1'b1;
    o_acc        = 1'b0;
    case (state)
      fcbf_pkg::ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          case (cmd.kind)
            fcbf_pkg::K_WRITE: begin
              load_out = 1'b1;
              if (count < eff_cap) begin
                mem_we      = 1'b1;
                tail_next   = ptr_inc(tail);
                count_next  = count + CW'(1);
                wtotal_next = wtotal + TW'(1);
                o_acc       = 1'b1;
              end
            end
            fcbf_pkg::K_READ, fcbf_pkg::K_PEEK: begin
              if (n == '0) begin
                load_out = 1'b1;
              end else begin
                ptr_next     = head;
                remain_next  = n;
                is_read_next = (cmd.kind == fcbf_pkg::K_READ);
                state_next   = fcbf_pkg::ST_FETCH;
              end
            end
            fcbf_pkg::K_POP: begin
              load_out    = 1'b1;
              head_next   = head_pop;
              count_next  = count - CW'(n);
              rtotal_next = rtotal + TW'(n);
            end
            fcbf_pkg::K_END: begin
              load_out   = 1'b1;
              ended_next = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      fcbf_pkg::ST_FETCH: begin
        state_next = fcbf_pkg::ST_EMIT;
      end
      fcbf_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out    = 1'b1;
          o_byte      = rd_data;
          o_bvalid    = 1'b1;
          o_last      = (remain == LW'(1));
          ptr_next    = ptr_inc(ptr);
          remain_next = remain - LW'(1);
          if (is_read) begin
            head_next   = ptr_inc(head);
            count_next  = count - CW'(1);
            rtotal_next = rtotal + TW'(1);
          end
          state_next = (remain == LW'(1)) ? fcbf_pkg::ST_IDLE : fcbf_pkg::ST_FETCH;
        end
      end
      default: begin
        state_next = fcbf_pkg::ST_IDLE;
      end
    endcase
  end

  assign free_next = (eff_cap > count_next) ? eff_cap - count_next : '0;

  // Update control state and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fcbf_pkg::ST_IDLE;
      capacity  <= fcbf_pkg::CAP_RESET;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      wtotal    <= '0;
      rtotal    <= '0;
      ended     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      wtotal <= wtotal_next;
      rtotal <= rtotal_next;
      ended  <= ended_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold burst bookkeeping
  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    remain  <= remain_next;
    is_read <= is_read_next;
  end

  // Write incoming bytes, read the byte at the burst pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= cmd.data_byte;
    end
    if (state == fcbf_pkg::ST_FETCH) begin
      rd_data <= mem[ptr];
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.out_byte      <= o_byte;
      rsp.byte_valid    <= o_bvalid;
      rsp.last          <= o_last;
      rsp.accepted      <= o_acc;
      rsp.occupancy     <= count_next;
      rsp.free_space    <= free_next;
      rsp.total_written <= wtotal_next;
      rsp.total_read    <= rtotal_next;
      rsp.input_done    <= ended_next;
      rsp.end_of_stream <= ended_next && (count_next == '0);
    end
  end

  assign rsp.valid = rsp_valid;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {21'b0, count} <= DEPTH32)
    else $error("byte count exceeds store depth");

  a_burst_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != fcbf_pkg::ST_IDLE) |-> (remain != '0))
    else $error("burst active with nothing left to deliver");

  a_fetch_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == fcbf_pkg::ST_FETCH) |=> (state == fcbf_pkg::ST_EMIT))
    else $error("store read not followed by delivery");

  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    ended |=> ended)
    else $error("end-of-input flag cleared without reset");
`endif

endmodule

// ===== sv/flow_controlled_byte_fifo.sv =====
// ----------------------------------------------------------------------------
// flow_controlled_byte_fifo: bounded byte FIFO with end-of-input mark
// Each request writes, reads, peeks, pops or marks end of input. Requests
// enter on cmd; results leave on rsp, one per delivered byte for read and
// peek, otherwise one per request, the final one carrying last.
// Capacity is set through cfg_we/cfg_data; the user must do so only while
// no request is in flight; the block does not enforce it. A single-result
// request passes the intake register and the command queue before the
// result register is loaded. Read and peek take each byte from the byte
// store in FETCH, a registered read, and load it in EMIT before fetching
// the next. One single-result request per cycle is taken while rsp is not
// stalled. A stalled rsp holds its result; the command queue and intake
// register keep taking up to three further requests before cmd.ready
// drops. Reset clears pointers, byte count, totals and end flag, sets
// capacity to 1024 and leaves the byte store contents undefined.
// ----------------------------------------------------------------------------
module flow_controlled_byte_fifo #(
  parameter int DEPTH     = fcbf_pkg::DEPTH_DEF,
  parameter int MAX_BURST = fcbf_pkg::MAX_BURST_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fcbf_pkg::COUNT_W-1:0]  cfg_data,
  fcbf_cmd_if.sink                      cmd,
  fcbf_rsp_if.source                    rsp
);

  logic           f_valid;
  logic           f_ready;
  fcbf_pkg::cmd_t f_cmd;
  logic           q_valid;
  logic           q_ready;
  fcbf_pkg::cmd_t q_cmd;

  // Classify incoming requests
  fcbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd)
  );

  // Buffer classified requests
  fcbf_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // Execute requests against the byte store
  fcbf_back #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .rsp       (rsp)
  );

endmodule

// ===== dv/flow_controlled_byte_fifo_tb.sv =====
// ----------------------------------------------------------------------------
// flow_controlled_byte_fifo_tb: self-checking bench for the bounded byte FIFO
// Drives write, read, peek, pop, end and unused requests under several
// capacities and idle patterns. A scoreboard mirrors the buffer, predicts
// every result record and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module flow_controlled_byte_fifo_tb;

  localparam int OP_W    = fcbf_pkg::OP_W;
  localparam int BYTE_W  = fcbf_pkg::BYTE_W;
  localparam int LEN_W   = fcbf_pkg::LEN_W;
  localparam int COUNT_W = fcbf_pkg::COUNT_W;
  localparam int TOTAL_W = fcbf_pkg::TOTAL_W;

  localparam int FIFO_DEPTH    = fcbf_pkg::DEPTH_DEF;
  localparam int BURST_MAX     = fcbf_pkg::MAX_BURST_DEF;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;

  // Op codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               last;
    logic               accepted;
    logic [COUNT_W-1:0] occupancy;
    logic [COUNT_W-1:0] free_space;
    logic [TOTAL_W-1:0] total_written;
    logic [TOTAL_W-1:0] total_read;
    logic               input_done;
    logic               end_of_stream;
  } fifo_status_t;

  // Mirror of the buffer plus the queue of result records still to arrive
  class byte_fifo_tracker_t;
    logic [BYTE_W-1:0]  store [FIFO_DEPTH];
    int unsigned        head;
    int unsigned        tail;
    int unsigned        held;
    int unsigned        written;
    int unsigned        removed;
    bit                 ended;
    logic [COUNT_W-1:0] capacity;
    fifo_status_t       expected_status[$];
    int                 mismatches;

    function new();
      head       = 0;
      tail       = 0;
      held       = 0;
      written    = 0;
      removed    = 0;
      ended      = 1'b0;
      capacity   = fcbf_pkg::CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [COUNT_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned limit();
      return (32'(capacity) > FIFO_DEPTH) ? FIFO_DEPTH : 32'(capacity);
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // Snapshot the status after the current change
    function void push_status(logic [BYTE_W-1:0] b, bit valid, bit is_last, bit acc);
      fifo_status_t s;
      s.out_byte      = b;
      s.byte_valid    = valid;
      s.last          = is_last;
      s.accepted      = acc;
      s.occupancy     = held[COUNT_W-1:0];
      s.free_space    = (limit() > held) ? COUNT_W'(limit() - held) : '0;
      s.total_written = written;
      s.total_read    = removed;
      s.input_done    = ended;
      s.end_of_stream = ended && (held == 0);
      expected_status.insert(expected_status.size(), s);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                               logic [LEN_W-1:0] len);
      int unsigned n;
      int unsigned p;
      bit          acc;
      n = 32'(len);
      if (n > held) n = held;
      if (n > BURST_MAX) n = BURST_MAX;
      case (op)
        fcbf_pkg::OP_WRITE: begin
          acc = held < limit();
          if (acc) begin
            store[tail] = data;
            tail = (tail + 1) % FIFO_DEPTH;
            held++;
            written++;
          end
          push_status('0, 1'b0, 1'b1, acc);
        end
        fcbf_pkg::OP_READ: begin
          if (n == 0) push_status('0, 1'b0, 1'b1, 1'b0);
          for (int i = 0; i < n; i++) begin
            p = head;
            head = (head + 1) % FIFO_DEPTH;
            held--;
            removed++;
            push_status(store[p], 1'b1, i == n - 1, 1'b0);
          end
        end
        fcbf_pkg::OP_PEEK: begin
          if (n == 0) push_status('0, 1'b0, 1'b1, 1'b0);
          p = head;
          for (int i = 0; i < n; i++) begin
            push_status(store[p], 1'b1, i == n - 1, 1'b0);
            p = (p + 1) % FIFO_DEPTH;
          end
        end
        fcbf_pkg::OP_POP: begin
          head = (head + n) % FIFO_DEPTH;
          held -= n;
          removed += n;
          push_status('0, 1'b0, 1'b1, 1'b0);
        end
        fcbf_pkg::OP_END: begin
          ended = 1'b1;
          push_status('0, 1'b0, 1'b1, 1'b0);
        end
        default: push_status('0, 1'b0, 1'b1, 1'b0);
      endcase
    endfunction

    function void check_field(string name, logic [TOTAL_W-1:0] want,
                              logic [TOTAL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one arriving result against the oldest prediction
    function void check_result(fifo_status_t got);
      fifo_status_t want;
      if (expected_status.size() == 0) begin
        $error("result: expected none, got out_byte %0d last %0d", got.out_byte, got.last);
        mismatches++;
        return;
      end
      want = expected_status[0];
      expected_status.delete(0);
      check_field("out_byte", TOTAL_W'(want.out_byte), TOTAL_W'(got.out_byte));
      check_field("byte_valid", TOTAL_W'(want.byte_valid), TOTAL_W'(got.byte_valid));
      check_field("last", TOTAL_W'(want.last), TOTAL_W'(got.last));
      check_field("accepted", TOTAL_W'(want.accepted), TOTAL_W'(got.accepted));
      check_field("occupancy", TOTAL_W'(want.occupancy), TOTAL_W'(got.occupancy));
      check_field("free_space", TOTAL_W'(want.free_space), TOTAL_W'(got.free_space));
      check_field("total_written", want.total_written, got.total_written);
      check_field("total_read", want.total_read, got.total_read);
      check_field("input_done", TOTAL_W'(want.input_done), TOTAL_W'(got.input_done));
      check_field("end_of_stream", TOTAL_W'(want.end_of_stream),
                  TOTAL_W'(got.end_of_stream));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_data;
  int                 send_idle_pct;
  int                 stall_pct;
  int                 quiet_cycles;
  fifo_status_t       seen;
  byte_fifo_tracker_t tracker = new();

  fcbf_cmd_if cmd_ch ();
  fcbf_rsp_if rsp_ch ();

  flow_controlled_byte_fifo dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd_ch),
    .rsp      (rsp_ch)
  );

  always #10 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Note accepted requests, check accepted results, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        tracker.note_request(cmd_ch.op, cmd_ch.data_byte, cmd_ch.length);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.out_byte      = rsp_ch.out_byte;
        seen.byte_valid    = rsp_ch.byte_valid;
        seen.last          = rsp_ch.last;
        seen.accepted      = rsp_ch.accepted;
        seen.occupancy     = rsp_ch.occupancy;
        seen.free_space    = rsp_ch.free_space;
        seen.total_written = rsp_ch.total_written;
        seen.total_read    = rsp_ch.total_read;
        seen.input_done    = rsp_ch.input_done;
        seen.end_of_stream = rsp_ch.end_of_stream;
        tracker.check_result(seen);
      end
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Present one request after a random gap and hold it until taken
  task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                              input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.op        <= op;
    cmd_ch.data_byte <= data;
    cmd_ch.length    <= len;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Hold off requests until every predicted result has arrived
  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [COUNT_W-1:0] value);
    wait_for_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tracker.set_capacity(value);
  endtask

  // Mostly short lengths, sometimes past the burst limit up to the field's top
  function automatic logic [LEN_W-1:0] random_length();
    int r;
    r = $urandom_range(99);
    if (r < 70) return LEN_W'($urandom_range(8));
    if (r < 95) return LEN_W'($urandom_range(BURST_MAX));
    return LEN_W'($urandom_range(127, BURST_MAX + 1));
  endfunction

  task automatic send_random(input int write_pct);
    logic [OP_W-1:0] op;
    int              r;
    if ($urandom_range(99) < write_pct) begin
      op = fcbf_pkg::OP_WRITE;
    end else begin
      r = $urandom_range(99);
      if (r < 38) op = fcbf_pkg::OP_READ;
      else if (r < 64) op = fcbf_pkg::OP_PEEK;
      else if (r < 88) op = fcbf_pkg::OP_POP;
      else begin
        case ($urandom_range(2))
          0:       op = OP_SPARE_5;
          1:       op = OP_SPARE_6;
          default: op = OP_SPARE_7;
        endcase
      end
    end
    send_request(op, BYTE_W'($urandom), random_length());
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.op        = fcbf_pkg::OP_WRITE;
    cmd_ch.data_byte = '0;
    cmd_ch.length    = '0;
    rsp_ch.ready     = 1'b0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty buffer: reads, peeks and pops give one status each; spare ops
    send_request(fcbf_pkg::OP_READ, BYTE_W'($urandom), 7'd5);
    send_request(fcbf_pkg::OP_PEEK, BYTE_W'($urandom), 7'd3);
    send_request(fcbf_pkg::OP_POP, BYTE_W'($urandom), 7'd2);
    send_request(OP_SPARE_5, 8'hFF, 7'd127);
    send_request(OP_SPARE_6, 8'h00, 7'd0);
    send_request(OP_SPARE_7, 8'h5A, 7'd64);
    send_request(fcbf_pkg::OP_WRITE, 8'h00, 7'd127);
    send_request(fcbf_pkg::OP_WRITE, 8'hFF, 7'd0);
    send_request(fcbf_pkg::OP_WRITE, 8'hA5, 7'd1);
    send_request(fcbf_pkg::OP_WRITE, 8'h5A, 7'd2);
    // Counts clamped to the bytes held; a zero count gives a status only
    send_request(fcbf_pkg::OP_PEEK, 8'h00, 7'd127);
    send_request(fcbf_pkg::OP_READ, 8'h00, 7'd0);
    send_request(fcbf_pkg::OP_READ, 8'h00, 7'd1);
    send_request(fcbf_pkg::OP_POP, 8'h00, 7'd1);

    // Lower capacity below occupancy: drop writes until reads make room
    write_capacity(11'd1);
    send_request(fcbf_pkg::OP_WRITE, 8'h3C, 7'd0);
    send_request(fcbf_pkg::OP_READ, 8'h00, 7'd1);
    send_request(fcbf_pkg::OP_WRITE, 8'hC3, 7'd0);
    send_request(fcbf_pkg::OP_READ, 8'h00, 7'd127);
    send_request(fcbf_pkg::OP_WRITE, 8'h81, 7'd0);
    send_request(fcbf_pkg::OP_WRITE, 8'h7E, 7'd0);

    // Zero capacity: every write is dropped
    write_capacity(11'd0);
    send_request(fcbf_pkg::OP_WRITE, 8'h42, 7'd0);
    send_request(fcbf_pkg::OP_READ, 8'h00, 7'd64);

    // Random phase: no idling, full capacity
    write_capacity(11'd1024);
    for (int i = 0; i < 10; i++) send_random(50);

    // Random phase: sender idles, small capacity
    write_capacity(11'd6);
    send_idle_pct = 62;
    for (int i = 0; i < 10; i++) send_random(55);

    // Capacity above the store size, receiver stalls; fill past one burst
    // and drain it with maximum length requests
    write_capacity(11'd2047);
    send_idle_pct = 0;
    stall_pct     = 62;
    for (int i = 0; i < 66; i++) begin
      send_request(fcbf_pkg::OP_WRITE, BYTE_W'($urandom), random_length());
    end
    send_request(fcbf_pkg::OP_PEEK, BYTE_W'($urandom), 7'd127);
    send_request(fcbf_pkg::OP_READ, BYTE_W'($urandom), 7'd127);
    send_request(fcbf_pkg::OP_POP, BYTE_W'($urandom), 7'd127);
    for (int i = 0; i < 6; i++) send_random(40);

    // End of input: writes still land, an emptied buffer ends the stream
    send_idle_pct = 21;
    stall_pct     = 21;
    wait_for_results();
    send_request(fcbf_pkg::OP_END, BYTE_W'($urandom), random_length());
    send_request(fcbf_pkg::OP_WRITE, 8'h11, 7'd0);
    send_request(fcbf_pkg::OP_READ, 8'h00, 7'd127);
    send_request(fcbf_pkg::OP_PEEK, 8'h00, 7'd4);

    // Random phase: both sides idle, capacity of two
    write_capacity(11'd2);
    for (int i = 0; i < 10; i++) send_random(50);

    wait_for_results();
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
